>>> rtl/core/pvd_pkg.sv
// Types and constants shared by the prefix varint decoder.
package pvd_pkg;

    localparam int MaxPrefixOnes = 6;
    localparam int BitsPerExtra  = 7;
    localparam int FirstMagBits  = 6;
    localparam int AccWidth      = 48;
    localparam int ValueWidth    = 49;
    localparam int LenWidth      = 3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       restart;
    } pvd_in_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic [LenWidth-1:0]          byte_count;
    } pvd_out_t;

    typedef struct packed {
        logic [LenWidth-1:0] bytes_left;
        logic [AccWidth-1:0] accumulator;
        logic                sign_flag;
        logic [LenWidth-1:0] total_length;
    } pvd_state_t;

    typedef struct packed {
        logic     res_valid;
        pvd_out_t res;
    } pvd_dec_t;

endpackage

>>> rtl/core/prefix_varint_decoder_core.sv
// Prefix varint decoder top level: decode state, result register and skid stage.
// A result is registered from the beat with its last byte, or in the skid register if stalled.
// Throughput: one byte per cycle while s_ready is high; a single decode step sits between state and result register.
// A skid register holds one more result while m_ready is low; s_ready drops only when it is full.
// Reset: synchronous active-low aresetn clears decode state and both valid flags.
module prefix_varint_decoder_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pvd_pkg::pvd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pvd_pkg::pvd_out_t m_data
);

    pvd_pkg::pvd_state_t state_reg;
    pvd_pkg::pvd_state_t state_next;
    pvd_pkg::pvd_dec_t   dec;
    pvd_pkg::pvd_out_t   m_data_reg;
    pvd_pkg::pvd_out_t   skid_reg;
    logic                m_valid_reg;
    logic                skid_valid_reg;
    logic                s_fire;
    logic                res_fire;
    logic                m_free;

    pvd_decode u_decode (
        .in_beat    (s_data),
        .state_cur  (state_reg),
        .state_next (state_next),
        .dec        (dec)
    );

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign res_fire = s_fire && dec.res_valid;
    assign m_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg <= state_next;
            end
            if (m_free) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    m_data_reg     <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= res_fire;
                    m_data_reg  <= dec.res;
                end
            end else if (res_fire) begin
                skid_reg       <= dec.res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bytes_left <= 3'(pvd_pkg::MaxPrefixOnes))
        else $error("bytes_left exceeds prefix limit");

    a_result_ends_int: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> (state_reg.bytes_left == '0))
        else $error("result emitted but integer not finished");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.byte_count != '0))
        else $error("result with zero byte count");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && res_fire) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

>>> rtl/core/pvd_decode.sv
// Per-byte decode step: prefix count, accumulate, and value formation.
module pvd_decode (
    input  pvd_pkg::pvd_in_t    in_beat,
    input  pvd_pkg::pvd_state_t state_cur,
    output pvd_pkg::pvd_state_t state_next,
    output pvd_pkg::pvd_dec_t   dec
);

    logic [7:0]                    b;
    logic [2:0]                    ones;
    logic [2:0]                    pos;
    logic [7:0]                    low_mask;
    logic [2:0]                    extra;
    logic [5:0]                    mag_bits;
    logic [pvd_pkg::ValueWidth-1:0] offset;
    logic [pvd_pkg::ValueWidth-1:0] diff;

    assign b = in_beat.byte_in;

    always_comb begin
        priority if (!b[7]) begin
            ones = 3'd0;
        end else if (!b[6]) begin
            ones = 3'd1;
        end else if (!b[5]) begin
            ones = 3'd2;
        end else if (!b[4]) begin
            ones = 3'd3;
        end else if (!b[3]) begin
            ones = 3'd4;
        end else if (!b[2]) begin
            ones = 3'd5;
        end else begin
            ones = 3'(pvd_pkg::MaxPrefixOnes);
        end
    end

    assign pos      = 3'(pvd_pkg::FirstMagBits) - ones;
    assign low_mask = (8'd1 << pos) - 8'd1;

    always_comb begin
        state_next = state_cur;
        if (in_beat.restart || (state_cur.bytes_left == '0)) begin
            state_next.sign_flag    = b[pos];
            state_next.accumulator  = pvd_pkg::AccWidth'(b & low_mask);
            state_next.total_length = ones + 3'd1;
            state_next.bytes_left   = ones;
        end else begin
            state_next.accumulator  = {state_cur.accumulator[pvd_pkg::AccWidth-9:0], b};
            state_next.bytes_left   = state_cur.bytes_left - 3'd1;
        end
    end

    // value = magnitude - sign * 2^(6 + 7 * (length - 1))
    assign extra    = state_next.total_length - 3'd1;
    assign mag_bits = 6'(pvd_pkg::FirstMagBits) + 6'(pvd_pkg::BitsPerExtra) * {3'd0, extra};
    assign offset   = pvd_pkg::ValueWidth'(state_next.sign_flag) << mag_bits;
    assign diff     = {1'b0, state_next.accumulator} - offset;

    assign dec.res_valid      = (state_next.bytes_left == '0);
    assign dec.res.value      = $signed(diff);
    assign dec.res.byte_count = state_next.total_length;

endmodule
